[hw/rtl/wpm_pkg.sv]
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

  localparam int unsigned MaxPatternDef = 32;

  localparam logic [7:0] StarByte  = 8'h2A;
  localparam logic [7:0] QmarkByte = 8'h3F;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TEXT   = 2'd2,
    REQ_FINISH = 2'd3
  } req_type_e;

  // item travelling down the cell row
  typedef struct packed {
    logic      valid;
    req_type_e op;
    logic [7:0] ch;
    logic      store;    // append actually writes a pattern byte
    logic      ovf;      // overflow flag sampled at finish
    logic      old_bit;  // previous cell's row bit before this item
    logic      new_bit;  // previous cell's row bit after this item
    logic      res;      // match result picked up on finish
  } wpm_tok_t;

endpackage

[hw/rtl/wpm_if.sv]
// ----------------------------------------------------------------------------
// wpm_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_byte;

  modport source (output valid, output req_type, output char_byte, input ready);
  modport sink   (input valid, input req_type, input char_byte, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

[hw/rtl/wildcard_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Matches a streamed text against a stored '?' / '*' wildcard pattern.
// ----------------------------------------------------------------------------
// One request item (clear, append, text byte, finish) is taken per cycle,
// so items may arrive back to back. Each item walks a row of MAX_PATTERN
// cells, one pattern position per cell and one cell per cycle; a finish
// item's result passes the head register, the cell registers and the
// output register, a delay set by the cell row's length. The row stalls,
// and ready drops, only while a result waits in the output register unread.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher import wpm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPatternDef,
  localparam int unsigned IdxW = $clog2(MAX_PATTERN + 1)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wpm_in_if.sink    in_i,
  wpm_out_if.source out_o
);

  logic            en;
  logic            accept;
  logic [IdxW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            m0_q, m0_d;
  wpm_tok_t        head_d;
  logic [IdxW-1:0] head_idx_d;
  wpm_tok_t        tok [MAX_PATTERN+1];
  logic [IdxW-1:0] idx [MAX_PATTERN+1];
  logic            out_valid_q;
  logic            matched_q;
  logic            ovf_out_q;
  wpm_tok_t        last;

  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;
  assign accept      = in_i.valid && en;

  always_comb begin
    len_d          = len_q;
    ovf_d          = ovf_q;
    m0_d           = m0_q;
    head_d         = '0;
    head_d.valid   = accept;
    head_d.op      = req_type_e'(in_i.req_type);
    head_d.ch      = in_i.char_byte;
    head_d.old_bit = m0_q;
    head_d.new_bit = 1'b1;
    head_idx_d     = len_q;
    if (accept) begin
      unique case (req_type_e'(in_i.req_type))
        REQ_CLEAR: begin
          len_d = '0;
          ovf_d = 1'b0;
          m0_d  = 1'b1;
        end
        REQ_APPEND: begin
          if (len_q < IdxW'(MAX_PATTERN)) begin
            len_d        = len_q + 1'b1;
            head_d.store = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          m0_d = 1'b1;
        end
        REQ_TEXT: begin
          m0_d           = 1'b0;
          head_d.new_bit = 1'b0;
        end
        REQ_FINISH: begin
          head_d.res = m0_q;
          head_d.ovf = ovf_q;
          m0_d       = 1'b1;
        end
        default: begin
          m0_d = m0_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      m0_q   <= 1'b1;
      tok[0] <= '0;
    end else if (en) begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      m0_q   <= m0_d;
      tok[0] <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx[0] <= head_idx_d;
    end
  end

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    wpm_cell #(
      .MAX_PATTERN(MAX_PATTERN)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .cell_idx_i(IdxW'(g + 1)),
      .tok_i     (tok[g]),
      .idx_i     (idx[g]),
      .tok_o     (tok[g+1]),
      .idx_o     (idx[g+1])
    );
  end

  assign last = tok[MAX_PATTERN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid && (last.op == REQ_FINISH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      matched_q <= last.res;
      ovf_out_q <= last.ovf;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.matched          = matched_q;
  assign out_o.pattern_overflow = ovf_out_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= IdxW'(MAX_PATTERN))
    else $error("pattern length beyond capacity");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.req_type == REQ_CLEAR) |=> (len_q == '0) && !ovf_q && m0_q)
    else $error("clear did not reset pattern state");

  a_text_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.req_type == REQ_TEXT) |=> !m0_q)
    else $error("text item left row bit zero set");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(last.valid && (last.op == REQ_FINISH)))
    else $error("result without finish item at end of row");

endmodule

[hw/rtl/wpm_cell.sv]
// ----------------------------------------------------------------------------
// wpm_cell
// One pattern position: holds a pattern byte and its match bit, updates the
// bit from the item passing through and hands the item to the next cell.
// ----------------------------------------------------------------------------
module wpm_cell import wpm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPatternDef,
  localparam int unsigned IdxW = $clog2(MAX_PATTERN + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [IdxW-1:0] cell_idx_i,
  input  wpm_tok_t        tok_i,
  input  logic [IdxW-1:0] idx_i,
  output wpm_tok_t        tok_o,
  output logic [IdxW-1:0] idx_o
);

  logic       m_q, m_d;
  logic       act_q, act_d;
  logic [7:0] p_q, p_d;
  logic       wr_here;
  logic       restart_bit;
  logic       text_bit;
  wpm_tok_t   tok_q, tok_d;
  logic [IdxW-1:0] idx_q;

  assign wr_here = (tok_i.op == REQ_APPEND) && tok_i.store &&
                   (idx_i == cell_idx_i - 1'b1);

  always_comb begin
    act_d = act_q;
    p_d   = p_q;
    if (tok_i.op == REQ_CLEAR) begin
      act_d = 1'b0;
    end else if (wr_here) begin
      act_d = 1'b1;
      p_d   = tok_i.ch;
    end
  end

  assign restart_bit = act_d && tok_i.new_bit && (p_d == StarByte);

  always_comb begin
    text_bit = 1'b0;
    if (act_q) begin
      priority if (p_q == StarByte) begin
        text_bit = m_q || tok_i.new_bit;
      end else if ((p_q == QmarkByte) || (p_q == tok_i.ch)) begin
        text_bit = tok_i.old_bit;
      end else begin
        text_bit = 1'b0;
      end
    end
  end

  assign m_d = (tok_i.op == REQ_TEXT) ? text_bit : restart_bit;

  always_comb begin
    tok_d         = tok_i;
    tok_d.old_bit = m_q;
    tok_d.new_bit = m_d;
    if ((tok_i.op == REQ_FINISH) && (idx_i == cell_idx_i)) begin
      tok_d.res = m_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q   <= 1'b0;
      act_q <= 1'b0;
      tok_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
      if (tok_i.valid) begin
        m_q   <= m_d;
        act_q <= act_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx_q <= idx_i;
      if (tok_i.valid) begin
        p_q <= p_d;
      end
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for wildcard_pattern_matcher. Drives clear, append, text and
// finish items through the request channel and keeps its own row of prefix
// match bits to predict the verdict of every finish. Each verdict on the
// result channel is checked against the oldest prediction. Directed tests
// cover empty patterns, byte extremes, wildcards against wildcard text bytes,
// appends in the middle of a text and pattern overflow. Random pattern/text
// sequences follow, mixed with noise. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import wpm_pkg::*;

  localparam int unsigned PatCap     = MaxPatternDef;
  localparam int unsigned RandItems  = 1500;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCyc   = PatCap + 8;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  wpm_in_if  req_if ();
  wpm_out_if res_if ();

  wildcard_pattern_matcher DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  // model of the matcher
  logic [7:0]    pat_mem [PatCap];
  int unsigned   pat_len;
  logic          pat_ovf;
  logic [PatCap:0] prefix_row;
  verdict_t      pending_verdicts [$];

  int unsigned sent_requests;
  int unsigned verdicts_seen;
  int unsigned hits_seen;
  int unsigned ovf_verdicts;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          source_steady;
  bit          sink_steady;

  function automatic void restart_row();
    prefix_row    = '0;
    prefix_row[0] = 1'b1;
    for (int unsigned j = 1; j <= pat_len; j++) begin
      prefix_row[j] = prefix_row[j-1] & (pat_mem[j-1] == StarByte);
    end
  endfunction

  function automatic void apply_request(req_type_e op, logic [7:0] ch);
    logic [PatCap:0] nxt;
    verdict_t        v;
    case (op)
      REQ_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        restart_row();
      end
      REQ_APPEND: begin
        if (pat_len < PatCap) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        restart_row();
      end
      REQ_TEXT: begin
        nxt = '0;
        for (int unsigned j = 1; j <= pat_len; j++) begin
          if (pat_mem[j-1] == StarByte) begin
            nxt[j] = prefix_row[j] | nxt[j-1];
          end else if (pat_mem[j-1] == QmarkByte || pat_mem[j-1] == ch) begin
            nxt[j] = prefix_row[j-1];
          end
        end
        prefix_row = nxt;
      end
      default: begin
        v.matched  = prefix_row[pat_len];
        v.overflow = pat_ovf;
        pending_verdicts.push_back(v);
        restart_row();
      end
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_req(req_type_e op, logic [7:0] ch);
    int unsigned gap;
    gap = source_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= op;
    req_if.char_byte <= ch;
    do @(posedge clk_i); while (!req_if.ready);
    apply_request(op, ch);
    sent_requests++;
  endtask

  function automatic logic [7:0] pick_pat_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return StarByte;
    if (r == 3) return QmarkByte;
    if (r < 9) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 10) return 8'h61 + 8'($urandom_range(0, 2));
    if (r < 12) return StarByte;
    if (r == 12) return QmarkByte;
    return 8'($urandom_range(0, 255));
  endfunction

  // result side: random stall before each verdict, then check it
  initial begin : result_sink
    int unsigned hold;
    verdict_t    exp_v;
    res_if.ready = 1'b0;
    sink_steady  = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hold = sink_steady ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      verdicts_seen++;
      if (res_if.matched) hits_seen++;
      if (res_if.pattern_overflow) ovf_verdicts++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected verdict: matched=%0b overflow=%0b",
                   res_if.matched, res_if.pattern_overflow);
        end
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (res_if.matched !== exp_v.matched ||
            res_if.pattern_overflow !== exp_v.overflow) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("verdict %0d mismatch: matched exp %0b got %0b, overflow exp %0b got %0b",
                     verdicts_seen, exp_v.matched, res_if.matched,
                     exp_v.overflow, res_if.pattern_overflow);
          end
        end
      end
      if (verdicts_seen % 20 == 0) sink_steady = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("[wildcard_pattern_matcher] ERROR");
      $finish;
    end
  end

  task automatic test_empty_pattern();
    send_req(REQ_FINISH, 8'h00);
    send_req(REQ_TEXT, 8'h61);
    send_req(REQ_FINISH, 8'hFF);
  endtask

  task automatic test_byte_extremes();
    send_req(REQ_CLEAR, 8'hFF);
    send_req(REQ_APPEND, 8'h00);
    send_req(REQ_APPEND, QmarkByte);
    send_req(REQ_APPEND, StarByte);
    send_req(REQ_APPEND, 8'hFF);
    send_req(REQ_TEXT, 8'h00);
    send_req(REQ_TEXT, StarByte);
    send_req(REQ_TEXT, 8'hFF);
    send_req(REQ_FINISH, 8'h00);
  endtask

  task automatic test_append_mid_text();
    send_req(REQ_CLEAR, 8'h00);
    send_req(REQ_APPEND, StarByte);
    send_req(REQ_FINISH, 8'h55);
    send_req(REQ_TEXT, 8'h71);
    send_req(REQ_APPEND, 8'h62);
    send_req(REQ_TEXT, 8'h62);
    send_req(REQ_FINISH, 8'hAA);
  endtask

  task automatic test_overflow();
    send_req(REQ_CLEAR, 8'h00);
    repeat (PatCap) send_req(REQ_APPEND, StarByte);
    send_req(REQ_APPEND, 8'h7A);
    send_req(REQ_TEXT, 8'h7A);
    send_req(REQ_FINISH, 8'h00);
    send_req(REQ_FINISH, 8'h00);
    send_req(REQ_CLEAR, 8'h00);
    send_req(REQ_FINISH, 8'h00);
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    repeat (n) send_req(req_type_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_pattern_run();
    int unsigned n_pat;
    int unsigned n_texts;
    int unsigned idx;
    int unsigned split;
    logic [7:0]  pat_q [$];
    logic [7:0]  txt [$];
    n_pat = ($urandom_range(0, 15) == 0) ? $urandom_range(PatCap - 4, PatCap + 4)
                                         : $urandom_range(0, 8);
    if ($urandom_range(0, 7) != 0) send_req(REQ_CLEAR, 8'($urandom_range(0, 255)));
    repeat (n_pat) begin
      pat_q.push_back(pick_pat_byte());
      send_req(REQ_APPEND, pat_q[$]);
    end
    n_texts = $urandom_range(1, 4);
    repeat (n_texts) begin
      txt.delete();
      foreach (pat_q[k]) begin
        if (k >= PatCap) break;
        if (pat_q[k] == StarByte) begin
          repeat ($urandom_range(0, 3)) txt.push_back(pick_text_byte());
        end else if (pat_q[k] == QmarkByte) begin
          txt.push_back(pick_text_byte());
        end else begin
          txt.push_back(pat_q[k]);
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        idx = (txt.size() == 0) ? 0 : $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 2))
          0: if (txt.size() > 0) txt[idx] = pick_text_byte();
          1: if (txt.size() > 0) txt.delete(idx);
          default: txt.insert(idx, pick_text_byte());
        endcase
      end
      split = ($urandom_range(0, 11) == 0) ? $urandom_range(0, txt.size()) : txt.size() + 1;
      foreach (txt[k]) begin
        if (k == split) send_req(REQ_APPEND, pick_pat_byte());
        send_req(REQ_TEXT, txt[k]);
      end
      send_req(REQ_FINISH, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_runs();
    int unsigned stop_at;
    stop_at = sent_requests + RandItems;
    while (sent_requests < stop_at) begin
      source_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_pattern_run();
    end
  endtask

  initial begin : stimulus
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_CLEAR;
    req_if.char_byte = 8'h00;
    rst_ni           = 1'b0;
    quiet_cycles     = 0;
    sent_requests    = 0;
    verdicts_seen    = 0;
    hits_seen        = 0;
    ovf_verdicts     = 0;
    mismatches       = 0;
    source_steady    = 1'b0;
    pat_len          = 0;
    pat_ovf          = 1'b0;
    restart_row();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pattern();
    test_byte_extremes();
    test_append_mid_text();
    test_overflow();
    test_random_runs();

    req_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);

    if (pending_verdicts.size() != 0) mismatches++;
    $display("sent %0d request items, checked %0d verdicts", sent_requests, verdicts_seen);
    $display("%0d verdicts matched, %0d reported overflow, %0d mismatches",
             hits_seen, ovf_verdicts, mismatches);
    if (mismatches == 0) begin
      $display("[wildcard_pattern_matcher] OK");
    end else begin
      $display("[wildcard_pattern_matcher] ERROR");
    end
    $finish;
  end

endmodule
